/* hw/rtl/filtered_velocity_estimator_macros.svh */
// assertion macros for the filtered velocity estimator
// included by the top level and the serial arithmetic unit
`ifndef FILTERED_VELOCITY_ESTIMATOR_MACROS_SVH
`define FILTERED_VELOCITY_ESTIMATOR_MACROS_SVH

// condition holds in the same cycle
`define FVE_ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fve same-cycle check failed");

// condition holds in the following cycle
`define FVE_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fve next-cycle check failed");

`endif

/* hw/rtl/fve_pkg.sv */
// shared constants, codes and types of the filtered velocity estimator
// no dependencies
`timescale 1ns / 1ps

package fve_pkg;

  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int POS_W   = 32;
  localparam int VEL_W   = 32;
  localparam int STAMP_W = 48;
  localparam int BW_W    = 17;
  localparam int SL_W    = 31;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 2'd1;

  localparam logic [STAMP_W-1:0] DT_MIN_US = 48'd100;
  localparam logic [19:0]        US_PER_S  = 20'd1000000;

  // serial unit operand and result widths
  localparam int OPA_W = 64;
  localparam int OPB_W = 48;
  localparam int RES_W = 80;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd32;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic             start;
    unit_op_t         op;
    logic [OPA_W-1:0] opa;
    logic [OPB_W-1:0] opb;
  } unit_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] res;
  } unit_rsp_t;

endpackage

/* hw/rtl/fve_if.sv */
// valid/ready channel interfaces: position samples, velocity results, register writes
// depends on fve_pkg
`timescale 1ns / 1ps

interface fve_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [fve_pkg::POS_W-1:0]  pos_x;
  logic signed [fve_pkg::POS_W-1:0]  pos_y;
  logic signed [fve_pkg::POS_W-1:0]  pos_z;
  logic        [fve_pkg::STAMP_W-1:0] time_stamp;

  modport source (output valid, pos_x, pos_y, pos_z, time_stamp, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, time_stamp, output ready);
endinterface

interface fve_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [fve_pkg::VEL_W-1:0] vel_x;
  logic signed [fve_pkg::VEL_W-1:0] vel_y;
  logic signed [fve_pkg::VEL_W-1:0] vel_z;
  logic                             recomputed;
  logic                             limited;

  modport source (output valid, vel_x, vel_y, vel_z, recomputed, limited, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, recomputed, limited, output ready);
endinterface

interface fve_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fve_pkg::CFG_IDX_W-1:0]     index;
  logic [fve_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/fve_serial_unit.sv */
// shared serial arithmetic unit: shift-add multiply, restoring divide, bitwise square root
// depends on fve_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "filtered_velocity_estimator_macros.svh"

module fve_serial_unit (
  input  logic               clk,
  input  logic               rst,
  input  fve_pkg::unit_req_t req,
  output fve_pkg::unit_rsp_t rsp
);

  localparam int OPA_W = fve_pkg::OPA_W;
  localparam int OPB_W = fve_pkg::OPB_W;
  localparam int RES_W = fve_pkg::RES_W;
  localparam int CNT_W = fve_pkg::CNT_W;

  logic              busy;
  logic              done;
  fve_pkg::unit_op_t op_r;
  logic [CNT_W-1:0]  cnt;

  logic [RES_W-1:0]  acc;
  logic [RES_W-1:0]  mcand;
  logic [31:0]       mplier;

  logic [OPB_W:0]    rem;
  logic [OPA_W-1:0]  quo;
  logic [OPB_W-1:0]  dvs;

  logic [OPA_W-1:0]  sx;
  logic [OPA_W-1:0]  sr;
  logic [OPA_W-1:0]  sbit;

  logic [OPB_W:0]    rem_sh;
  logic              div_ge;
  logic [OPA_W-1:0]  trial;
  logic              sq_ge;

  always_comb begin
    rem_sh = {rem[OPB_W-1:0], quo[OPA_W-1]};
    div_ge = rem_sh >= {1'b0, dvs};
    trial  = sr + sbit;
    sq_ge  = sx >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= fve_pkg::OP_MUL;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        op_r <= req.op;
        case (req.op)
          fve_pkg::OP_MUL: begin
            cnt    <= fve_pkg::MUL_STEPS;
            acc    <= '0;
            mcand  <= RES_W'(req.opa[OPB_W-1:0]);
            mplier <= req.opb[31:0];
          end
          fve_pkg::OP_DIV: begin
            cnt <= fve_pkg::DIV_STEPS;
            rem <= '0;
            quo <= req.opa;
            dvs <= req.opb;
          end
          fve_pkg::OP_SQRT: begin
            cnt  <= fve_pkg::SQRT_STEPS;
            sx   <= req.opa;
            sr   <= '0;
            sbit <= 64'h4000_0000_0000_0000;
          end
          default: begin
            cnt <= fve_pkg::MUL_STEPS;
          end
        endcase
      end else if (busy) begin
        case (op_r)
          fve_pkg::OP_MUL: begin
            if (mplier[0]) begin
              acc <= acc + mcand;
            end
            mcand  <= {mcand[RES_W-2:0], 1'b0};
            mplier <= {1'b0, mplier[31:1]};
          end
          fve_pkg::OP_DIV: begin
            rem <= div_ge ? rem_sh - {1'b0, dvs} : rem_sh;
            quo <= {quo[OPA_W-2:0], div_ge};
          end
          fve_pkg::OP_SQRT: begin
            if (sq_ge) begin
              sx <= sx - trial;
              sr <= {1'b0, sr[OPA_W-1:1]} + sbit;
            end else begin
              sr <= {1'b0, sr[OPA_W-1:1]};
            end
            sbit <= {2'b00, sbit[OPA_W-1:2]};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    case (op_r)
      fve_pkg::OP_MUL:  rsp.res = acc;
      fve_pkg::OP_DIV:  rsp.res = RES_W'(quo);
      fve_pkg::OP_SQRT: rsp.res = RES_W'(sr);
      default:          rsp.res = acc;
    endcase
  end

  `FVE_ASSERT_SAME(a_start_idle, clk, rst, req.start, !busy)
  `FVE_ASSERT_NEXT(a_start_busy, clk, rst, req.start, busy && !done)
  `FVE_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)

endmodule

/* hw/rtl/filtered_velocity_estimator.sv */
// A first sample or an interval of 100 us or less goes from idle straight to the done state;
// other samples are recomputed per axis, then checked against a nonzero speed limit, and
// scaled by the norm clamp (after pre-shifting the magnitudes) when the limit binds.
// Throughput: one sample at a time, ready again right after the result register loads; set by
// the shared serial unit (32-step multiply and 64-step divide per axis, one 32-step square root).
// Reset (rst, synchronous): state, estimate and configuration registers cleared, no result pending.
`timescale 1ns / 1ps
`include "filtered_velocity_estimator_macros.svh"

module filtered_velocity_estimator #(
  parameter int WEIGHT_FRAC_BITS = fve_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fve_sample_if.sink   sample,
  fve_result_if.source result,
  fve_cfg_if.sink      cfg
);

  localparam int W      = WEIGHT_FRAC_BITS;
  localparam int AW     = W + 1;
  localparam int BW_W   = fve_pkg::BW_W;
  localparam int CMP_W  = (BW_W > AW) ? BW_W : AW;
  localparam int V_W    = 48;
  localparam int NUM_W  = W + V_W;
  localparam int MAG_W  = V_W;
  localparam int OPA_W  = fve_pkg::OPA_W;
  localparam int OPB_W  = fve_pkg::OPB_W;
  localparam int SL_W   = fve_pkg::SL_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_US,
    ST_DIV_DT,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_LSQ,
    ST_SQRT,
    ST_MUL_LIM,
    ST_DIV_N,
    ST_DONE
  } state_t;

  state_t state;
  logic [1:0] axis;

  logic                        has_prev;
  logic signed [31:0]          last_pos [3];
  logic        [47:0]          last_stamp;
  logic signed [31:0]          vel [3];
  logic signed [31:0]          pos_l [3];
  logic        [47:0]          stamp_l;
  logic        [47:0]          dt_r;
  logic                        sd;
  logic        [45:0]          q_r;
  logic signed [NUM_W-1:0]     num;
  logic signed [V_W-1:0]       v_new [3];
  logic        [MAG_W-1:0]     mag [3];
  logic                        shifted;
  logic        [63:0]          sq;
  logic        [32:0]          n_r;
  logic                        upd;
  logic                        rec;
  logic                        lim;

  logic [BW_W-1:0] blend_weight;
  logic [SL_W-1:0] speed_limit;

  logic               ov;
  logic signed [31:0] ox, oy, oz;
  logic               orc, olm;

  fve_pkg::unit_req_t req;
  fve_pkg::unit_rsp_t rsp;

  fve_serial_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // blend weight clamped to one
  logic [CMP_W-1:0]        bw_ext;
  logic [CMP_W-1:0]        one_ext;
  logic [AW-1:0]           a_eff;
  logic [AW-1:0]           one_minus_a;
  logic signed [32:0]      diff_c;
  logic [32:0]             ad_c;
  logic [31:0]             vel_abs_c;
  logic signed [NUM_W-1:0] p_c;
  logic signed [NUM_W-1:0] num_sum_c;
  logic signed [V_W-1:0]   m_c;
  logic                    any_hi;
  logic [1:0]              axis_nx;
  logic [47:0]             dt_c;
  logic [32:0]             n_c;

  always_comb begin
    bw_ext      = CMP_W'(blend_weight);
    one_ext     = CMP_W'(1) << W;
    a_eff       = (bw_ext > one_ext) ? one_ext[AW-1:0] : bw_ext[AW-1:0];
    one_minus_a = (AW'(1) << W) - a_eff;
    diff_c      = {pos_l[axis][31], pos_l[axis]} - {last_pos[axis][31], last_pos[axis]};
    ad_c        = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
    vel_abs_c   = vel[axis][31] ? 32'(-vel[axis]) : 32'(vel[axis]);
    p_c         = rsp.res[NUM_W-1:0];
    num_sum_c   = num + (sd ? -p_c : p_c);
    m_c         = V_W'(rsp.res[31:0]);
    any_hi      = (|mag[0][MAG_W-1:31]) | (|mag[1][MAG_W-1:31]) | (|mag[2][MAG_W-1:31]);
    axis_nx     = axis + 2'd1;
    dt_c        = sample.time_stamp - last_stamp;
    n_c         = (rsp.res[32:0] == '0) ? 33'd1 : rsp.res[32:0];
  end

  function automatic logic signed [31:0] sat32(input logic signed [V_W-1:0] v);
    if (!v[V_W-1] && (|v[V_W-2:31])) begin
      return 32'sh7fff_ffff;
    end else if (v[V_W-1] && !(&v[V_W-2:31])) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign sample.ready     = (state == ST_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = ov;
  assign result.vel_x     = ox;
  assign result.vel_y     = oy;
  assign result.vel_z     = oz;
  assign result.recomputed = orc;
  assign result.limited   = olm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      axis         <= '0;
      has_prev     <= 1'b0;
      last_stamp   <= '0;
      blend_weight <= '0;
      speed_limit  <= '0;
      ov           <= 1'b0;
      req          <= '0;
      for (int i = 0; i < 3; i++) begin
        last_pos[i] <= '0;
        vel[i]      <= '0;
      end
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          fve_pkg::CFG_BLEND_WEIGHT: blend_weight <= cfg.data[BW_W-1:0];
          fve_pkg::CFG_SPEED_LIMIT:  speed_limit  <= cfg.data[SL_W-1:0];
          default: ;
        endcase
      end

      // the done state reloads the result register itself
      if (ov && result.ready && (state != ST_DONE)) begin
        ov <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          req.start <= 1'b0;
          if (sample.valid) begin
            pos_l[0] <= sample.pos_x;
            pos_l[1] <= sample.pos_y;
            pos_l[2] <= sample.pos_z;
            stamp_l  <= sample.time_stamp;
            dt_r     <= dt_c;
            rec      <= 1'b0;
            lim      <= 1'b0;
            axis     <= '0;
            if (!has_prev) begin
              upd      <= 1'b1;
              has_prev <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                v_new[i] <= '0;
              end
              state <= ST_DONE;
            end else if (dt_c <= fve_pkg::DT_MIN_US) begin
              upd   <= 1'b0;
              state <= ST_DONE;
            end else begin
              upd   <= 1'b1;
              rec   <= 1'b1;
              state <= ST_DIFF;
            end
          end
        end

        ST_DIFF: begin
          sd        <= diff_c[32];
          req.start <= 1'b1;
          req.op    <= fve_pkg::OP_MUL;
          req.opa   <= OPA_W'(ad_c);
          req.opb   <= OPB_W'(fve_pkg::US_PER_S);
          state     <= ST_MUL_US;
        end

        ST_MUL_US: begin
          if (rsp.done) begin
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_DIV;
            req.opa   <= rsp.res[OPA_W-1:0];
            req.opb   <= dt_r;
            state     <= ST_DIV_DT;
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_DIV_DT: begin
          if (rsp.done) begin
            q_r       <= rsp.res[45:0];
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_MUL;
            req.opa   <= OPA_W'(vel_abs_c);
            req.opb   <= OPB_W'(a_eff);
            state     <= ST_MUL_OLD;
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_MUL_OLD: begin
          if (rsp.done) begin
            num       <= vel[axis][31] ? -p_c : p_c;
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_MUL;
            req.opa   <= OPA_W'(q_r);
            req.opb   <= OPB_W'(one_minus_a);
            state     <= ST_MUL_NEW;
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_MUL_NEW: begin
          req.start <= 1'b0;
          if (rsp.done) begin
            // floor division by one is the arithmetic upper part
            v_new[axis] <= num_sum_c[NUM_W-1:W];
            if (axis == 2'd2) begin
              state <= (speed_limit == '0) ? ST_DONE : ST_MAG;
            end else begin
              axis  <= axis_nx;
              state <= ST_DIFF;
            end
          end
        end

        ST_MAG: begin
          req.start <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= v_new[i][V_W-1] ? MAG_W'(-v_new[i]) : MAG_W'(v_new[i]);
          end
          shifted <= 1'b0;
          state   <= ST_NORM;
        end

        ST_NORM: begin
          if (any_hi) begin
            req.start <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              mag[i] <= {1'b0, mag[i][MAG_W-1:1]};
            end
            shifted <= 1'b1;
          end else begin
            axis      <= '0;
            sq        <= '0;
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_MUL;
            req.opa   <= OPA_W'(mag[0]);
            req.opb   <= OPB_W'(mag[0]);
            state     <= ST_SQ;
          end
        end

        ST_SQ: begin
          if (rsp.done) begin
            sq        <= sq + rsp.res[63:0];
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_MUL;
            if (axis == 2'd2) begin
              req.opa <= OPA_W'(speed_limit);
              req.opb <= OPB_W'(speed_limit);
              state   <= ST_LSQ;
            end else begin
              axis    <= axis_nx;
              req.opa <= OPA_W'(mag[axis_nx]);
              req.opb <= OPB_W'(mag[axis_nx]);
            end
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_LSQ: begin
          if (rsp.done) begin
            if (shifted || (sq > rsp.res[63:0])) begin
              lim       <= 1'b1;
              req.start <= 1'b1;
              req.op    <= fve_pkg::OP_SQRT;
              req.opa   <= sq;
              req.opb   <= '0;
              state     <= ST_SQRT;
            end else begin
              req.start <= 1'b0;
              state     <= ST_DONE;
            end
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_SQRT: begin
          if (rsp.done) begin
            n_r       <= n_c;
            axis      <= '0;
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_MUL;
            req.opa   <= OPA_W'(mag[0]);
            req.opb   <= OPB_W'(speed_limit);
            state     <= ST_MUL_LIM;
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_MUL_LIM: begin
          if (rsp.done) begin
            req.start <= 1'b1;
            req.op    <= fve_pkg::OP_DIV;
            req.opa   <= rsp.res[OPA_W-1:0];
            req.opb   <= OPB_W'(n_r);
            state     <= ST_DIV_N;
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_DIV_N: begin
          if (rsp.done) begin
            // sign of the unclamped axis carries over
            v_new[axis] <= v_new[axis][V_W-1] ? -m_c : m_c;
            if (axis == 2'd2) begin
              req.start <= 1'b0;
              state     <= ST_DONE;
            end else begin
              axis      <= axis_nx;
              req.start <= 1'b1;
              req.op    <= fve_pkg::OP_MUL;
              req.opa   <= OPA_W'(mag[axis_nx]);
              req.opb   <= OPB_W'(speed_limit);
              state     <= ST_MUL_LIM;
            end
          end else begin
            req.start <= 1'b0;
          end
        end

        ST_DONE: begin
          req.start <= 1'b0;
          if (!ov || result.ready) begin
            for (int i = 0; i < 3; i++) begin
              last_pos[i] <= pos_l[i];
            end
            last_stamp <= stamp_l;
            if (upd) begin
              for (int i = 0; i < 3; i++) begin
                vel[i] <= sat32(v_new[i]);
              end
              ox <= sat32(v_new[0]);
              oy <= sat32(v_new[1]);
              oz <= sat32(v_new[2]);
            end else begin
              ox <= vel[0];
              oy <= vel[1];
              oz <= vel[2];
            end
            orc   <= rec;
            olm   <= lim;
            ov    <= 1'b1;
            state <= ST_IDLE;
          end
        end

        default: begin
          req.start <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  logic [31:0] out_abs_x;
  assign out_abs_x = result.vel_x[31] ? 32'(-result.vel_x) : 32'(result.vel_x);

  `FVE_ASSERT_SAME(a_limited_recomputed, clk, rst, result.valid && result.limited, result.recomputed)
  `FVE_ASSERT_SAME(a_limited_bound, clk, rst, result.valid && result.limited, out_abs_x <= 32'(speed_limit))
  `FVE_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample.valid && sample.ready, !sample.ready)

endmodule
